### rtl/acd_pkg.sv
`timescale 1ns / 1ps
package acd_pkg;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_INST = 2'd1,
        KIND_GEN  = 2'd2,
        KIND_END  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  word_index;
        logic [63:0] entropy_word;
        logic [63:0] pers_word;
        logic [4:0]  take_bytes;
    } in_item_t;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [4:0]  bytes_valid;
        logic [31:0] reseed_count;
    } out_item_t;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic        gen;
        logic        inst;
        logic [4:0]  take;
    } cmd_t;

    localparam int SEED_WORDS = 6;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [4:0] BLK_BYTES = 5'd16;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // SubBytes, ShiftRows and, unless last, MixColumns. Byte 0 is bits 127:120.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] sb [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            sb[i] = s[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int row = 0; row < 4; row++) begin
                t[4*c+row] = SBOX[sb[4*((c+row)%4)+row]];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = t[i];
        end
        aes_round = r;
    endfunction

endpackage

### rtl/aes256_ctr_drbg.sv
`timescale 1ns / 1ps
// Channel | Signals                       | Direction
// in      | in_valid, in_ready, in_data   | request beats into the block
// out     | out_valid, out_ready, out_data| generated block beats out
//
// A generate holds the engine for command pickup, key load with the initial
// round key, fourteen iterated AES rounds and a closing step.
// Instantiate and end run three encryptions; loads do not use the engine.
// A two-entry command queue sits between the front and the AES engine.
// Reset clears key, V, counter and the instantiated flag; the seed is not reset.
// A stalled output holds the engine; the queue takes up to two more commands,
// and loads wait until the queue and the engine are both idle.
module aes256_ctr_drbg
    import acd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    logic         cmd_valid, cmd_ready;
    cmd_t         cmd;
    logic [383:0] seed;

    acd_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_data,
        .cmd_valid, .cmd_ready, .cmd, .seed
    );

    acd_core u_core (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .seed,
        .out_valid, .out_ready, .out_data
    );

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.bytes_valid != 5'd0 && out_data.bytes_valid <= BLK_BYTES))
        else $error("bytes_valid out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid)
        else $error("queued command lost");
endmodule

### rtl/acd_front.sv
`timescale 1ns / 1ps
// Takes input beats, keeps the seed, and queues the commands that need AES work.
module acd_front
    import acd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  in_item_t     in_data,
    output logic         cmd_valid,
    input  logic         cmd_ready,
    output cmd_t         cmd,
    output logic [383:0] seed
);
    localparam int QD = 2;

    logic [63:0] seed_reg [SEED_WORDS];
    cmd_t        q_reg [QD];
    logic        rd_ptr_reg, rd_ptr_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        take_in, push, pop;
    cmd_t        new_cmd;
    logic [4:0]  take_sat;

    // The seed must not change under an instantiate that is still in the queue
    // or in the engine, so loads wait until both are idle.
    assign in_ready = (cnt_reg == 2'd0 && cmd_ready) ||
                      (cnt_reg < 2'(QD) && in_data.kind != KIND_LOAD);
    assign take_in  = in_valid && in_ready;
    assign push     = take_in && in_data.kind != KIND_LOAD;
    assign pop      = cmd_valid && cmd_ready;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        if (in_data.take_bytes == 5'd0)
            take_sat = 5'd1;
        else if (in_data.take_bytes > BLK_BYTES)
            take_sat = BLK_BYTES;
        else
            take_sat = in_data.take_bytes;
        new_cmd.gen  = in_data.kind == KIND_GEN;
        new_cmd.inst = in_data.kind == KIND_INST;
        new_cmd.take = take_sat;
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= new_cmd;
        if (take_in && in_data.kind == KIND_LOAD && in_data.word_index < 3'(SEED_WORDS))
            seed_reg[in_data.word_index] <= in_data.entropy_word ^ in_data.pers_word;
    end

    assign seed = {seed_reg[0], seed_reg[1], seed_reg[2], seed_reg[3], seed_reg[4], seed_reg[5]};
endmodule

### rtl/acd_core.sv
`timescale 1ns / 1ps
// Executes generate and update commands on one iterated AES-256 round.
module acd_core
    import acd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    output logic         cmd_ready,
    input  cmd_t         cmd,
    input  logic [383:0] seed,
    output logic         out_valid,
    input  logic         out_ready,
    output out_item_t    out_data
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_KEY  = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    logic [255:0]   key_reg;
    logic [127:0]   v_reg;
    logic [31:0]    count_reg;
    logic           inst_reg;
    // Expanding key schedule: two most recent round-key words groups.
    logic [255:0]   ks_reg;
    logic [7:0]     rc_reg;
    logic [3:0]     round_reg;
    logic [127:0]   st_reg;
    logic [1:0]     blk_reg;
    logic [383:0]   acc_reg;
    cmd_t           c_reg;
    logic           ov_reg;
    out_item_t      od_reg;

    logic [127:0]   v_inc, rk, rs, st_new;
    logic [255:0]   ks_step, key_use;
    logic [127:0]   v_use;
    logic [31:0]    w0, w1, w2, w3, w4, w5, w6, w7, t;
    logic           last;
    logic [383:0]   upd;

    assign cmd_ready = state_reg == ST_IDLE && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // At the start of a command the key and V come from state, or zero for instantiate.
    assign key_use = c_reg.inst ? 256'd0 : key_reg;
    assign v_use   = (c_reg.inst && blk_reg == 2'd0) ? 128'd0 : v_reg;
    assign v_inc   = v_use + 128'd1;

    // Round keys: odd rounds use the lower half of ks, even ones the upper half.
    // The schedule advances after every odd round.
    always_comb
    begin
        {w0, w1, w2, w3, w4, w5, w6, w7} = ks_reg;
        t = sub_word({w7[23:0], w7[31:24]}) ^ {rc_reg, 24'd0};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        t = sub_word(w3);
        w4 = w4 ^ t; w5 = w5 ^ w4; w6 = w6 ^ w5; w7 = w7 ^ w6;
        ks_step = {w0, w1, w2, w3, w4, w5, w6, w7};
        rk = round_reg[0] ? ks_reg[127:0] : ks_reg[255:128];
        last = round_reg == 4'd14;
        rs = aes_round(st_reg, last);
        st_new = rs ^ rk;
        upd = acc_reg ^ (c_reg.inst ? seed : 384'd0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cmd_valid && cmd_ready) state_next = ST_KEY;
            ST_KEY:  state_next = ST_RUN;
            ST_RUN:  if (last) state_next = (c_reg.gen || blk_reg == 2'd2) ? ST_DONE : ST_KEY;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            key_reg   <= '0;
            v_reg     <= '0;
            count_reg <= '0;
            inst_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            blk_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    blk_reg <= 2'd0;
                    if (cmd_valid && cmd_ready && cmd.gen && !inst_reg)
                    begin
                        key_reg  <= '0;
                        inst_reg <= 1'b1;
                    end
                end
                ST_KEY:
                begin
                    v_reg <= v_inc;
                end
                ST_RUN:
                begin
                    if (last)
                    begin
                        if (c_reg.gen)
                        begin
                            ov_reg <= 1'b1;
                            od_reg.block_high   <= st_new[127:64];
                            od_reg.block_low    <= st_new[63:0];
                            od_reg.bytes_valid  <= c_reg.take;
                            od_reg.reseed_count <= count_reg;
                        end
                        else if (blk_reg != 2'd2)
                            blk_reg <= blk_reg + 2'd1;
                    end
                end
                ST_DONE:
                begin
                    if (!c_reg.gen)
                    begin
                        key_reg  <= upd[383:128];
                        v_reg    <= upd[127:0];
                        inst_reg <= 1'b1;
                        if (c_reg.inst)
                            count_reg <= 32'd1;
                        else if (count_reg != COUNT_MAX)
                            count_reg <= count_reg + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid && cmd_ready)
            c_reg <= cmd;
        if (state_reg == ST_KEY)
        begin
            ks_reg    <= key_use;
            rc_reg    <= 8'h01;
            round_reg <= 4'd1;
            st_reg    <= v_inc ^ key_use[255:128];
        end
        else if (state_reg == ST_RUN)
        begin
            st_reg    <= st_new;
            round_reg <= round_reg + 4'd1;
            if (round_reg[0])
            begin
                ks_reg <= ks_step;
                rc_reg <= xtime(rc_reg);
            end
            if (last)
                acc_reg[383-128*blk_reg -: 128] <= st_new;
        end
    end
endmodule

### tb/aes256_ctr_drbg_tb.sv
`timescale 1ns / 1ps
module aes256_ctr_drbg_tb;
    import acd_pkg::*;

    localparam int RANDOM_BEATS = 1500;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 200;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    aes256_ctr_drbg i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the generator state.
    logic [255:0] drbg_key;
    logic [127:0] drbg_v;
    logic [63:0]  seed_words [SEED_WORDS];
    logic [31:0]  reseeds;
    logic         keyed;

    out_item_t pending_blocks [$];
    int        errors;
    int        beats_sent;
    bit        burst;
    bit        hold_req;
    longint    cycles;

    typedef struct {
        in_item_t   beat;
        bit         typed;
        logic [4:0] bv;
        logic [31:0] rc;
    } stim_row_t;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        gf_double = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes256_block(input logic [255:0] key,
                                                  input logic [127:0] pt);
        logic [7:0] rk [240];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a [4];
        logic [7:0] f, rcon, a0, a1, a2, a3, all;
        logic [127:0] res;
        rcon = 8'h01;
        for (int i = 0; i < 32; i++) rk[i] = key[255-8*i -: 8];
        for (int i = 8; i < 60; i++) begin
            for (int k = 0; k < 4; k++) a[k] = rk[4*(i-1)+k];
            if (i % 8 == 0) begin
                f = a[0];
                a[0] = SBOX[a[1]] ^ rcon;
                a[1] = SBOX[a[2]];
                a[2] = SBOX[a[3]];
                a[3] = SBOX[f];
                rcon = gf_double(rcon);
            end
            else if (i % 8 == 4) begin
                for (int k = 0; k < 4; k++) a[k] = SBOX[a[k]];
            end
            for (int k = 0; k < 4; k++) rk[4*i+k] = rk[4*(i-8)+k] ^ a[k];
        end
        for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ rk[i];
        for (int r = 1; r <= 14; r++) begin
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    t[4*c+row] = SBOX[s[4*((c+row)%4)+row]];
            if (r != 14) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                    t[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                    t[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                    t[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
        aes256_block = res;
    endfunction

    function automatic logic [127:0] next_keystream();
        drbg_v = drbg_v + 128'd1;
        next_keystream = aes256_block(drbg_key, drbg_v);
    endfunction

    function automatic void reseed_update(input bit with_seed);
        logic [383:0] tmp;
        tmp[383:256] = next_keystream();
        tmp[255:128] = next_keystream();
        tmp[127:0]   = next_keystream();
        if (with_seed)
            tmp ^= {seed_words[0], seed_words[1], seed_words[2],
                    seed_words[3], seed_words[4], seed_words[5]};
        drbg_key = tmp[383:128];
        drbg_v   = tmp[127:0];
        keyed    = 1'b1;
    endfunction

    // Advances the shadow state by one accepted request beat.
    function automatic void predict_request(input in_item_t it);
        out_item_t o;
        logic [127:0] blk;
        case (kind_t'(it.kind))
            KIND_LOAD: begin
                if (it.word_index < SEED_WORDS)
                    seed_words[it.word_index] = it.entropy_word ^ it.pers_word;
            end
            KIND_INST: begin
                drbg_key = '0;
                drbg_v   = '0;
                reseed_update(1'b1);
                reseeds = 32'd1;
            end
            KIND_END: begin
                reseed_update(1'b0);
                if (reseeds != COUNT_MAX) reseeds = reseeds + 32'd1;
            end
            default: begin
                if (!keyed) begin
                    drbg_key = '0;
                    keyed = 1'b1;
                end
                blk = next_keystream();
                o.block_high = blk[127:64];
                o.block_low  = blk[63:0];
                if (it.take_bytes == 5'd0) o.bytes_valid = 5'd1;
                else if (it.take_bytes > BLK_BYTES) o.bytes_valid = BLK_BYTES;
                else o.bytes_valid = it.take_bytes;
                o.reseed_count = reseeds;
                pending_blocks.push_back(o);
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) pick_gap = 0;
        else if (r < 92) pick_gap = $urandom_range(1, 3);
        else pick_gap = $urandom_range(10, 40);
    endfunction

    task automatic send_request(input stim_row_t row);
        int n;
        n = burst ? 0 : pick_gap();
        @(negedge clk);
        if (n > 0) begin
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = row.beat;
        do @(posedge clk); while (!in_ready);
        predict_request(row.beat);
        if (row.typed) begin
            pending_blocks[$].bytes_valid  = row.bv;
            pending_blocks[$].reseed_count = row.rc;
        end
        beats_sent++;
    endtask

    function automatic stim_row_t mk(input kind_t k, input logic [2:0] idx,
                                     input logic [63:0] e, input logic [63:0] p,
                                     input logic [4:0] tk, input bit typed,
                                     input logic [4:0] bv, input logic [31:0] rc);
        stim_row_t r;
        r.beat.kind = k;
        r.beat.word_index = idx;
        r.beat.entropy_word = e;
        r.beat.pers_word = p;
        r.beat.take_bytes = tk;
        r.typed = typed;
        r.bv = bv;
        r.rc = rc;
        mk = r;
    endfunction

    function automatic stim_row_t random_request();
        int r;
        kind_t k;
        r = $urandom_range(0, 99);
        if (r < 30) k = KIND_LOAD;
        else if (r < 75) k = KIND_GEN;
        else if (r < 90) k = KIND_END;
        else k = KIND_INST;
        random_request = mk(k, (r % 10 == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(0, 5)),
                            {$urandom, $urandom}, ($urandom_range(0, 3) == 0) ? 64'd0
                            : {$urandom, $urandom}, 5'($urandom_range(0, 31)),
                            1'b0, 5'd0, 32'd0);
    endfunction

    // Output checker.
    always @(posedge clk) begin
        out_item_t exp;
        if (rst_n && out_valid && out_ready) begin
            if (pending_blocks.size() == 0) begin
                $error("unexpected output beat %h", out_data);
                errors++;
            end
            else begin
                exp = pending_blocks.pop_front();
                if (out_data.block_high !== exp.block_high) begin
                    $error("block_high expected %h actual %h", exp.block_high,
                           out_data.block_high);
                    errors++;
                end
                if (out_data.block_low !== exp.block_low) begin
                    $error("block_low expected %h actual %h", exp.block_low,
                           out_data.block_low);
                    errors++;
                end
                if (out_data.bytes_valid !== exp.bytes_valid) begin
                    $error("bytes_valid expected %0d actual %0d", exp.bytes_valid,
                           out_data.bytes_valid);
                    errors++;
                end
                if (out_data.reseed_count !== exp.reseed_count) begin
                    $error("reseed_count expected %0d actual %0d", exp.reseed_count,
                           out_data.reseed_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("aes256_ctr_drbg_tb: FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, and one long hold-off so the command queue fills.
    initial begin
        int stall;
        int hold;
        stall = 0;
        hold = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold = 600;
            end
            if (hold > 0) begin
                hold--;
                out_ready = 1'b0;
            end
            else if (stall > 0) begin
                stall--;
                out_ready = 1'b0;
            end
            else if (burst) begin
                out_ready = 1'b1;
            end
            else begin
                if ($urandom_range(0, 99) < 3) stall = $urandom_range(10, 60);
                out_ready = ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        stim_row_t rows [$];
        drbg_key = '0;
        drbg_v = '0;
        reseeds = '0;
        keyed = 1'b0;
        for (int i = 0; i < SEED_WORDS; i++) seed_words[i] = '0;
        errors = 0;
        beats_sent = 0;
        burst = 1'b0;
        hold_req = 1'b0;
        cycles = 0;
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;

        // Generate before instantiation runs on the all-zero key.
        rows.push_back(mk(KIND_GEN, 3'd0, '0, '0, 5'd0, 1'b1, 5'd1, 32'd0));
        rows.push_back(mk(KIND_GEN, 3'd7, '1, '1, 5'd16, 1'b1, 5'd16, 32'd0));
        // End before instantiation updates with the current key.
        rows.push_back(mk(KIND_END, 3'd0, '0, '0, 5'd0, 1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_GEN, 3'd0, '0, '0, 5'd31, 1'b1, 5'd16, 32'd1));
        rows.push_back(mk(KIND_LOAD, 3'd0, '1, '0, 5'd0, 1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_LOAD, 3'd1, '0, '1, 5'd0, 1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_LOAD, 3'd2, '1, '1, 5'd0, 1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_LOAD, 3'd3, 64'h0123456789abcdef, '0, 5'd0,
                          1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_LOAD, 3'd4, 64'h8000000000000001, 64'h1, 5'd0,
                          1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_LOAD, 3'd5, '0, '0, 5'd0, 1'b0, 5'd0, 32'd0));
        // Loads beyond the last seed word are dropped.
        rows.push_back(mk(KIND_LOAD, 3'd6, '1, '0, 5'd0, 1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_LOAD, 3'd7, '1, '0, 5'd0, 1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_INST, 3'd0, '0, '0, 5'd0, 1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_GEN, 3'd0, '0, '0, 5'd1, 1'b1, 5'd1, 32'd1));
        rows.push_back(mk(KIND_END, 3'd0, '0, '0, 5'd0, 1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_GEN, 3'd0, '0, '0, 5'd8, 1'b1, 5'd8, 32'd2));
        rows.push_back(mk(KIND_GEN, 3'd0, '0, '0, 5'd17, 1'b1, 5'd16, 32'd2));
        rows.push_back(mk(KIND_GEN, 3'd0, '0, '0, 5'd15, 1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_INST, 3'd0, '0, '0, 5'd0, 1'b0, 5'd0, 32'd0));
        rows.push_back(mk(KIND_GEN, 3'd0, '0, '0, 5'd31, 1'b1, 5'd16, 32'd1));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i]) send_request(rows[i]);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 100 == 0) burst = ($urandom_range(0, 3) == 0);
            if (n == 300) begin
                burst = 1'b1;
                hold_req = 1'b1;
            end
            send_request(random_request());
        end
        @(negedge clk);
        in_valid = 1'b0;

        while (pending_blocks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_blocks.size() == 0)
            $display("aes256_ctr_drbg_tb: PASS");
        else
            $display("aes256_ctr_drbg_tb: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/acd_pkg.sv
rtl/acd_front.sv
rtl/acd_core.sv
rtl/aes256_ctr_drbg.sv
tb/aes256_ctr_drbg_tb.sv
